### sv/tmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed message deframer package
// Shared types and constants for the deframer core, the result queue and
// the channel interfaces.
// ----------------------------------------------------------------------------
package tmd_pkg;

   localparam int MaxFields   = 16;
   localparam int TypeSlots   = 16;
   localparam int FieldLimit  = (MaxFields < TypeSlots) ? MaxFields : TypeSlots;

   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 16;
   localparam int TypesWidth  = 32;
   localparam int CountWidth  = 5;
   localparam int IndexWidth  = 4;
   localparam int ValueWidth  = 64;
   localparam int EventWidth  = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = 32;

   localparam logic [CsrIdxWidth-1:0] CSR_EXPECTED_ID   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_EXPECTED_SIZE = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FIELD_TYPES   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_FIELD_COUNT   = 3'd3;

   localparam logic [ByteWidth-1:0]  RESET_EXPECTED_ID   = 8'd0;
   localparam logic [LenWidth-1:0]   RESET_EXPECTED_SIZE = 16'd8;
   localparam logic [TypesWidth-1:0] RESET_FIELD_TYPES   = 32'd10;
   localparam logic [CountWidth-1:0] RESET_FIELD_COUNT   = 5'd2;

   typedef enum logic [EventWidth-1:0] {
      EV_FIELD       = 2'd0,
      EV_DONE        = 2'd1,
      EV_IGNORE_ID   = 2'd2,
      EV_IGNORE_SIZE = 2'd3
   } event_type;

   typedef enum logic [3:0] {
      PH_ID      = 4'b0001,
      PH_LEN_HI  = 4'b0010,
      PH_LEN_LO  = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   typedef struct packed {
      event_type              event_res;
      logic [IndexWidth-1:0]  field_index;
      logic [ValueWidth-1:0]  field_value;
      logic [ByteWidth-1:0]   message_id;
      logic                   last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage
`default_nettype wire

### sv/tmd_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed message deframer channels
// Valid/ready interfaces for the received byte stream and the result stream.
// ----------------------------------------------------------------------------
interface tmd_req_if
   import tmd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tmd_rsp_if
   import tmd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [EventWidth-1:0] event_res;
   logic [IndexWidth-1:0] field_index;
   logic [ValueWidth-1:0] field_value;
   logic [ByteWidth-1:0]  message_id;
   logic                  last;

   modport source (output valid, output event_res, output field_index,
                   output field_value, output message_id, output last,
                   input ready);
   modport sink (input valid, input event_res, input field_index,
                 input field_value, input message_id, input last,
                 output ready);
endinterface
`default_nettype wire

### sv/tmd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed message deframer core
// Holds the configuration registers and the header and field state, and
// produces up to two results for every accepted byte.
// ----------------------------------------------------------------------------
module tmd_core
   import tmd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [ByteWidth-1:0]   rx_byte,
   input  wire logic                   csr_write_enable,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrWidth-1:0]    csr_wdata,
   output push_type                    push
);

   logic [ByteWidth-1:0]  expected_id_ff;
   logic [LenWidth-1:0]   expected_size_ff;
   logic [TypesWidth-1:0] field_types_ff;
   logic [CountWidth-1:0] field_count_ff;

   phase_type             phase_ff, phase_in;
   logic [ByteWidth-1:0]  header_id_ff, header_id_in;
   logic [ByteWidth-1:0]  length_high_ff, length_high_in;
   logic [LenWidth-1:0]   remaining_ff, remaining_in;
   logic                  skipping_ff, skipping_in;
   logic [CountWidth-1:0] current_field_ff, current_field_in;
   logic [2:0]            byte_count_ff, byte_count_in;
   logic [ValueWidth-1:0] accum_ff, accum_in;

   logic [CountWidth-1:0] eff_count;

   always_comb begin
      if (field_count_ff > CountWidth'(FieldLimit)) begin
         eff_count = CountWidth'(FieldLimit);
      end else begin
         eff_count = field_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff   <= RESET_EXPECTED_ID;
         expected_size_ff <= RESET_EXPECTED_SIZE;
         field_types_ff   <= RESET_FIELD_TYPES;
         field_count_ff   <= RESET_FIELD_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPECTED_ID:   expected_id_ff   <= csr_wdata[ByteWidth-1:0];
            CSR_EXPECTED_SIZE: expected_size_ff <= csr_wdata[LenWidth-1:0];
            CSR_FIELD_TYPES:   field_types_ff   <= csr_wdata[TypesWidth-1:0];
            CSR_FIELD_COUNT:   field_count_ff   <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [LenWidth-1:0]   len;
      logic                  skip_now;
      logic [1:0]            code;
      logic [3:0]            size;
      logic [3:0]            count_next;
      logic [ValueWidth-1:0] accum_next;
      logic                  field_done;
      rsp_item_type          blank;

      len        = {length_high_ff, rx_byte};
      skip_now   = 1'b0;
      code       = 2'd0;
      size       = 4'd1;
      count_next = 4'd0;
      accum_next = '0;
      field_done = 1'b0;

      blank.event_res   = EV_FIELD;
      blank.field_index = '0;
      blank.field_value = '0;
      blank.message_id  = header_id_ff;
      blank.last        = 1'b0;

      phase_in         = phase_ff;
      header_id_in     = header_id_ff;
      length_high_in   = length_high_ff;
      remaining_in     = remaining_ff;
      skipping_in      = skipping_ff;
      current_field_in = current_field_ff;
      byte_count_in    = byte_count_ff;
      accum_in         = accum_ff;
      push.count       = 2'd0;
      push.item0       = blank;
      push.item1       = blank;

      if (accept) begin
         unique case (phase_ff)
            PH_ID: begin
               header_id_in = rx_byte;
               phase_in     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_high_in = rx_byte;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               current_field_in = '0;
               byte_count_in    = '0;
               accum_in         = '0;
               remaining_in     = len;
               if (header_id_ff != expected_id_ff) begin
                  skip_now             = 1'b1;
                  push.count           = 2'd1;
                  push.item0.event_res = EV_IGNORE_ID;
               end else if (len != expected_size_ff) begin
                  skip_now             = 1'b1;
                  push.count           = 2'd1;
                  push.item0.event_res = EV_IGNORE_SIZE;
               end
               skipping_in = skip_now;
               if (len == '0) begin
                  phase_in = PH_ID;
                  if (!skip_now) begin
                     push.count           = 2'd1;
                     push.item0.event_res = EV_DONE;
                  end
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               remaining_in = remaining_ff - LenWidth'(1);
               if (!skipping_ff && (current_field_ff < eff_count)) begin
                  code       = field_types_ff[2*current_field_ff[IndexWidth-1:0] +: 2];
                  size       = 4'd1 << code;
                  accum_next = {accum_ff[ValueWidth-ByteWidth-1:0], rx_byte};
                  count_next = {1'b0, byte_count_ff} + 4'd1;
                  if (count_next >= size) begin
                     field_done             = 1'b1;
                     push.count             = 2'd1;
                     push.item0.event_res   = EV_FIELD;
                     push.item0.field_index = current_field_ff[IndexWidth-1:0];
                     push.item0.field_value = accum_next;
                     accum_in               = '0;
                     byte_count_in          = '0;
                     current_field_in       = current_field_ff + CountWidth'(1);
                  end else begin
                     accum_in      = accum_next;
                     byte_count_in = count_next[2:0];
                  end
               end
               if (remaining_in == '0) begin
                  phase_in = PH_ID;
                  if (!skipping_ff) begin
                     if (field_done) begin
                        push.count           = 2'd2;
                        push.item1.event_res = EV_DONE;
                     end else begin
                        push.count           = 2'd1;
                        push.item0.event_res = EV_DONE;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_ID;
            end
         endcase
      end

      if (push.count == 2'd2) begin
         push.item1.last = 1'b1;
      end else if (push.count == 2'd1) begin
         push.item0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_ID;
         header_id_ff     <= '0;
         length_high_ff   <= '0;
         remaining_ff     <= '0;
         skipping_ff      <= 1'b0;
         current_field_ff <= '0;
         byte_count_ff    <= '0;
         accum_ff         <= '0;
      end else begin
         phase_ff         <= phase_in;
         header_id_ff     <= header_id_in;
         length_high_ff   <= length_high_in;
         remaining_ff     <= remaining_in;
         skipping_ff      <= skipping_in;
         current_field_ff <= current_field_in;
         byte_count_ff    <= byte_count_in;
         accum_ff         <= accum_in;
      end
   end

   // A message in its payload always has at least one byte left to take.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != '0))
      else $error("payload phase with no bytes remaining");

   // No field is decoded while a message is being skipped.
   assert property (@(posedge clock) disable iff (reset)
      (accept && skipping_ff && (phase_ff == PH_PAYLOAD)) |-> (push.count != 2'd2))
      else $error("field decoded in a skipped message");

   // The phase register always holds exactly one active phase.
   assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   // The field position never runs past the type list.
   assert property (@(posedge clock) disable iff (reset)
      current_field_ff <= CountWidth'(FieldLimit))
      else $error("field position beyond the type list");

endmodule
`default_nettype wire

### sv/tmd_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed message deframer result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// result transaction per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tmd_rsp_queue
   import tmd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  push_type    push,
   output logic        space_ok,
   output logic        out_valid,
   input  wire logic   out_ready,
   output rsp_item_type out_item
);

   localparam int Depth = 4;

   rsp_item_type entries_ff [Depth];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   assign space_ok  = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + 2'd1] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Results are only pushed when there is room for two of them.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("result pushed into a full queue");

   // The fill level follows the pushes and pops of the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) + {1'b0, $past(push.count)}
                - {2'b00, $past(pop)}))
      else $error("queue fill level out of step");

   // The fill level stays within the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(Depth))
      else $error("queue overflow");

   // A waiting head result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
      else $error("head result changed while stalled");

endmodule
`default_nettype wire

### sv/typed_message_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed message deframer unit
// Deframes id/length headed messages from a byte stream and decodes the
// payload into big-endian fields by a configured type list.
// Results: each result is written into the result queue registers and is
// offered from there, behind any results already waiting. Throughput: one
// byte per cycle while the queue holds at most two results; one result
// transaction leaves per cycle while the receiver is ready, so a byte that
// ends a field and a message yields two output transactions.
// Reset: registers return to their reset values, state clears, queue empties.
// ----------------------------------------------------------------------------
module typed_message_deframer_unit
   import tmd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   tmd_req_if.sink                     req_channel,
   tmd_rsp_if.source                   rsp_channel,
   input  wire logic                   csr_write_enable,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrWidth-1:0]    csr_wdata
);

   push_type     push;
   logic         space_ok;
   logic         accept;
   rsp_item_type head;

   assign req_channel.ready = space_ok;
   assign accept            = req_channel.valid && space_ok;

   tmd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .rx_byte          (req_channel.rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push)
   );

   tmd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_channel.valid),
      .out_ready (rsp_channel.ready),
      .out_item  (head)
   );

   assign rsp_channel.event_res   = head.event_res;
   assign rsp_channel.field_index = head.field_index;
   assign rsp_channel.field_value = head.field_value;
   assign rsp_channel.message_id  = head.message_id;
   assign rsp_channel.last        = head.last;

endmodule
`default_nettype wire
